// ===== rtl/vtm_pkg.sv =====
`default_nettype none

package vtm_pkg;

   // row geometry
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH     = 2 * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);

   // pixel format
   localparam int PIX_W     = 32;
   localparam int BYTE_W    = 8;
   localparam int NBYTES    = PIX_W / BYTE_W;

   // configuration port
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int MODE_W    = 3;
   localparam int PROG_W    = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRESS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd2;

   localparam logic [MODE_W-1:0] MODE_CUT      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DISSOLVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WIPE     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SLIDE    = 3'd4;

   localparam logic [PROG_W-1:0] PROG_FULL = 9'd256;
   localparam logic [PROG_W-1:0] PROG_HALF = 9'd128;

   localparam int RESET_WIDTH = (2048 > MAX_WIDTH) ? MAX_WIDTH : 2048;

   // settled configuration, with the wipe boundary worked out at write time
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PROG_W-1:0] prog;
      logic [WID_W-1:0]  width;
      logic [WID_W-1:0]  bnd;
      logic [WID_W-1:0]  start;
   } cfg_type;

   // per item selection carried from address stage to mix stage
   typedef struct packed {
      logic blend;
      logic sel_b;
      logic last;
   } mix_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/vtm_ram.sv =====
`default_nettype none

module vtm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vtm_csr.sv =====
`default_nettype none

module vtm_csr import vtm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   output cfg_type                   cfg
);

   cfg_type                   cfg_ff, cfg_in;
   logic [MODE_W-1:0]         mode_nx;
   logic [PROG_W-1:0]         prog_nx;
   logic [WID_W-1:0]          width_nx;
   logic [WID_W+PROG_W-1:0]   prod;

   always_comb begin
      mode_nx  = cfg_ff.mode;
      prog_nx  = cfg_ff.prog;
      width_nx = cfg_ff.width;
      if (csr_write) begin
         case (csr_index)
            CSR_MODE: begin
               mode_nx = csr_data[MODE_W-1:0];
            end
            CSR_PROGRESS: begin
               // saturate at full
               prog_nx = (csr_data[PROG_W-1:0] > PROG_FULL) ? PROG_FULL
                                                            : csr_data[PROG_W-1:0];
            end
            CSR_ROW_WIDTH: begin
               if (csr_data == '0) begin
                  width_nx = WID_W'(1);
               end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
                  width_nx = WID_W'(MAX_WIDTH);
               end else begin
                  width_nx = WID_W'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
      prod         = (WID_W+PROG_W)'(width_nx) * (WID_W+PROG_W)'(prog_nx);
      cfg_in.mode  = mode_nx;
      cfg_in.prog  = prog_nx;
      cfg_in.width = width_nx;
      cfg_in.bnd   = prod[WID_W+BYTE_W-1:BYTE_W];
      cfg_in.start = width_nx - prod[WID_W+BYTE_W-1:BYTE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= MODE_CUT;
         cfg_ff.prog  <= '0;
         cfg_ff.width <= WID_W'(RESET_WIDTH);
         cfg_ff.bnd   <= '0;
         cfg_ff.start <= WID_W'(RESET_WIDTH);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/vtm_ctrl.sv =====
`default_nettype none

module vtm_ctrl import vtm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              flush,
   input  cfg_type                cfg,
   output logic                   has_result,
   output logic                   load,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [ADDR_W-1:0]      rd_addr_a,
   output logic [ADDR_W-1:0]      rd_addr_b,
   output mix_ctl_type            ctl
);

   logic [COL_W-1:0] col_ff, col_in;
   logic             bank_ff, bank_in;
   logic             ready_ff, ready_in;
   logic [WID_W-1:0] xw;
   logic             last;
   logic             take;
   logic             in_b_region;
   logic [COL_W-1:0] col_a;
   logic [COL_W-1:0] col_b;

   function automatic logic [ADDR_W-1:0] row_addr(input logic bank, input logic [COL_W-1:0] c);
      logic [ADDR_W-1:0] base;
      base     = bank ? ADDR_W'(MAX_WIDTH) : '0;
      row_addr = base + ADDR_W'(c);
   endfunction

   always_comb begin
      xw          = WID_W'(col_ff);
      last        = (xw + WID_W'(1)) >= cfg.width;
      // a flush with nothing stored is dropped
      take        = accept && !(flush && !ready_ff);
      in_b_region = xw >= cfg.start;

      col_a = col_ff;
      col_b = col_ff;
      ctl.blend = 1'b0;
      ctl.last  = last;
      case (cfg.mode)
         MODE_CUT: begin
            ctl.sel_b = cfg.prog >= PROG_HALF;
         end
         MODE_DISSOLVE: begin
            ctl.sel_b = 1'b0;
            ctl.blend = 1'b1;
         end
         MODE_WIPE: begin
            ctl.sel_b = xw < cfg.bnd;
         end
         MODE_PUSH: begin
            ctl.sel_b = in_b_region;
            col_a     = COL_W'(xw + cfg.bnd);
            col_b     = COL_W'(xw - cfg.start);
         end
         MODE_SLIDE: begin
            ctl.sel_b = in_b_region;
            col_b     = COL_W'(xw - cfg.start);
         end
         default: begin
            ctl.sel_b = cfg.prog >= PROG_FULL;
         end
      endcase

      col_in   = col_ff;
      bank_in  = bank_ff;
      ready_in = ready_ff;
      if (take) begin
         if (last) begin
            col_in   = '0;
            bank_in  = !bank_ff;
            ready_in = !flush;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         bank_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         bank_ff  <= bank_in;
         ready_ff <= ready_in;
      end
   end

   assign has_result = ready_ff;
   assign load       = accept && ready_ff;
   assign wr_en      = take && !flush;
   assign wr_addr    = row_addr(bank_ff, col_ff);
   assign rd_addr_a  = row_addr(!bank_ff, col_a);
   assign rd_addr_b  = row_addr(!bank_ff, col_b);

endmodule

`default_nettype wire

// ===== rtl/vtm_mix.sv =====
`default_nettype none

module vtm_mix import vtm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  mix_ctl_type            ctl,
   input  wire logic [PIX_W-1:0]  data_a,
   input  wire logic [PIX_W-1:0]  data_b,
   input  wire logic [PROG_W-1:0] prog,
   input  wire logic              rsp_stall,
   output logic                   up_stall,
   output logic                   rsp_valid,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic                   rsp_last_in_row
);

   logic              s1_valid_ff, s1_valid_in;
   mix_ctl_type       s1_ctl_ff;
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  pixel_ff;
   logic              last_ff;
   logic              advance;
   logic [PIX_W-1:0]  blended;
   logic [PIX_W-1:0]  mixed;
   logic [PROG_W-1:0] inv_prog;
   logic [2*BYTE_W:0] acc;

   always_comb begin
      inv_prog = PROG_FULL - prog;
      blended  = '0;
      acc      = '0;
      for (int i = 0; i < NBYTES; i++) begin
         acc = (2*BYTE_W+1)'(data_a[i*BYTE_W +: BYTE_W]) * (2*BYTE_W+1)'(inv_prog)
             + (2*BYTE_W+1)'(data_b[i*BYTE_W +: BYTE_W]) * (2*BYTE_W+1)'(prog);
         blended[i*BYTE_W +: BYTE_W] = acc[2*BYTE_W-1:BYTE_W];
      end
      if (s1_ctl_ff.blend) begin
         mixed = blended;
      end else if (s1_ctl_ff.sel_b) begin
         mixed = data_b;
      end else begin
         mixed = data_a;
      end

      advance      = !out_valid_ff || !rsp_stall;
      up_stall     = s1_valid_ff && !advance;
      s1_valid_in  = load || (s1_valid_ff && !advance);
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ctl_ff <= ctl;
      end
      if (advance && s1_valid_ff) begin
         pixel_ff <= mixed;
         last_ff  <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_out   = pixel_ff;
   assign rsp_last_in_row = last_ff;

endmodule

`default_nettype wire

// ===== rtl/video_transition_mixer.sv =====
// video transition mixer: takes one A/B BGRA pixel pair per item, row by row, and
// writes it into one bank of a ping-pong row store while the row before it is read
// from the other bank and mixed, so results lag the input by one row; an item with
// flush set emits the next stored pixel without storing, which drains the last row,
// and a flush with no row stored is taken and dropped. the block takes one item
// per clock unless the output stalls; a result goes through the row store read
// register, then the output register. the two row store memories each give one
// read and one write a cycle; the wipe boundary (width*progress)>>8 is worked out
// when a register is written. the user must write mode, progress and row_width
// only while no item is in flight; the block does not enforce it. there is no
// clearing pass after reset: none is needed, as a row is read only once written.
`default_nettype none

module video_transition_mixer import vtm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input items
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIX_W-1:0]     req_pixel_a,
   input  wire logic [PIX_W-1:0]     req_pixel_b,
   input  wire logic                 req_flush,
   // result items
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [PIX_W-1:0]          rsp_pixel_out,
   output logic                      rsp_last_in_row,
   // register writes
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   cfg_type           cfg;
   mix_ctl_type       ctl;
   logic              accept;
   logic              has_result;
   logic              load;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [PIX_W-1:0]  data_a;
   logic [PIX_W-1:0]  data_b;
   logic              up_stall;

   assign accept    = req_valid && !up_stall;
   assign req_stall = up_stall;

   // configuration registers and derived boundary
   vtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // column counter, bank toggle and row store addressing
   vtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .flush      (req_flush),
      .cfg        (cfg),
      .has_result (has_result),
      .load       (load),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .ctl        (ctl)
   );

   // outgoing frame row store, both banks
   vtm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_a),
      .rd_en   (load),
      .rd_addr (rd_addr_a),
      .rd_data (data_a)
   );

   // incoming frame row store, both banks
   vtm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_b),
      .rd_en   (load),
      .rd_addr (rd_addr_b),
      .rd_data (data_b)
   );

   // select or blend, then output register
   vtm_mix u_mix (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .ctl             (ctl),
      .data_a          (data_a),
      .data_b          (data_b),
      .prog            (cfg.prog),
      .rsp_stall       (rsp_stall),
      .up_stall        (up_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_in_row (rsp_last_in_row)
   );

   // the input side is held back only by a blocked full output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output register can drain");

   // reads of the previous row never touch the entry being filled
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      (load && wr_en) |-> ((rd_addr_a != wr_addr) && (rd_addr_b != wr_addr)))
      else $error("row store read and write hit the same entry");

   // a row closed by a pair leaves a row ready for output
   a_row_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_flush && ctl.last) |=> has_result)
      else $error("completed row not marked ready");

endmodule

`default_nettype wire
